// ----- src/crld_pkg.sv -----
// shared types and constants of the cluster run list decoder
`default_nettype none

package crld_pkg;

  // field and datapath widths
  localparam int CLUSTER_BITS    = 48;
  localparam int MAX_FIELD_BYTES = 8;
  localparam int LIMIT_BITS      = (CLUSTER_BITS < 48) ? CLUSTER_BITS : 48;
  localparam int ACC_W           = 64;
  localparam int CNT_W           = 48;
  localparam int ADDR_W          = 63;
  localparam int SECTOR_W        = 13;
  localparam int CSECT_W         = 8;
  localparam int STREAM_W        = 48;
  localparam int CB_W            = SECTOR_W + CSECT_W;
  localparam int PROD_W          = CNT_W + CB_W;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // back end: signed start add and result queue
  localparam int SUM_W    = ACC_W + 1;
  localparam int OQ_DEPTH = 2;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SECTOR_BYTES    = 2'd0;
  localparam reg_idx_t REG_CLUSTER_SECTORS = 2'd1;
  localparam reg_idx_t REG_STREAM_BYTES    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_NIBBLE = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;

  typedef enum logic {
    CMD_END,
    CMD_RUN
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] run_byte;
    logic       list_start;
  } in_word_t;

  typedef struct packed {
    logic              run_valid;
    logic [CNT_W-1:0]  run_start;
    logic [CNT_W-1:0]  cluster_count;
    logic [ADDR_W-1:0] byte_address;
    logic              list_done;
    logic [1:0]        status;
  } out_word_t;

  // one parsed event handed from the front to the back
  typedef struct packed {
    logic             clr;
    cmd_kind_t        kind;
    logic [1:0]       status;
    logic [3:0]       off_size;
    logic [ACC_W-1:0] off_acc;
    logic [ACC_W-1:0] len_acc;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/crld_front.sv -----
// byte parser: header nibbles, little-endian field gathering, end and error detection
`default_nettype none

module crld_front import crld_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_word_t in_word,
  output logic          cmd_push,
  output cmd_t          cmd_word
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET
  } phase_t;

  phase_t           phase_r, phase_nxt, phase_e;
  logic [3:0]       ls_r, ls_nxt;
  logic [3:0]       os_r, os_nxt;
  logic [3:0]       idx_r, idx_nxt, idx_e, idx_inc;
  logic [ACC_W-1:0] len_r, len_nxt, len_e;
  logic [ACC_W-1:0] off_r, off_nxt, off_e;
  logic             fin_r, fin_nxt, fin_e;
  logic             clr_pend_r, clr_pend_nxt;
  logic [3:0]       hdr_ls, hdr_os;
  logic [ACC_W-1:0] byte_sh;

  always_comb begin
    // a new list wipes the partial run before the byte is looked at
    phase_e = phase_r;
    idx_e   = idx_r;
    len_e   = len_r;
    off_e   = off_r;
    fin_e   = fin_r;
    if (in_word.list_start) begin
      phase_e = PH_HEADER;
      idx_e   = '0;
      len_e   = '0;
      off_e   = '0;
      fin_e   = 1'b0;
    end

    hdr_ls  = in_word.run_byte[3:0];
    hdr_os  = in_word.run_byte[7:4];
    idx_inc = idx_e + 4'd1;
    byte_sh = ACC_W'(in_word.run_byte) << {idx_e[2:0], 3'b000};

    phase_nxt    = phase_r;
    ls_nxt       = ls_r;
    os_nxt       = os_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    off_nxt      = off_r;
    fin_nxt      = fin_r;
    clr_pend_nxt = clr_pend_r;

    cmd_push          = 1'b0;
    cmd_word.clr      = clr_pend_r | in_word.list_start;
    cmd_word.kind     = CMD_END;
    cmd_word.status   = ST_OK;
    cmd_word.off_size = os_r;
    cmd_word.off_acc  = off_e | byte_sh;
    cmd_word.len_acc  = len_e;

    if (accept) begin
      phase_nxt = phase_e;
      idx_nxt   = idx_e;
      len_nxt   = len_e;
      off_nxt   = off_e;
      fin_nxt   = fin_e;
      if (!fin_e) begin
        case (phase_e)
          PH_HEADER: begin
            if (hdr_os == 4'd0) begin
              // end marker
              cmd_push = 1'b1;
              fin_nxt  = 1'b1;
            end else if (hdr_ls > 4'(MAX_FIELD_BYTES) || hdr_os > 4'(MAX_FIELD_BYTES)) begin
              cmd_push        = 1'b1;
              cmd_word.status = ST_BAD_NIBBLE;
              fin_nxt         = 1'b1;
            end else begin
              ls_nxt    = hdr_ls;
              os_nxt    = hdr_os;
              len_nxt   = '0;
              off_nxt   = '0;
              idx_nxt   = '0;
              phase_nxt = (hdr_ls != 4'd0) ? PH_LENGTH : PH_OFFSET;
            end
          end
          PH_LENGTH: begin
            len_nxt = len_e | byte_sh;
            if (idx_inc >= ls_r) begin
              idx_nxt   = '0;
              phase_nxt = PH_OFFSET;
            end else begin
              idx_nxt = idx_inc;
            end
          end
          PH_OFFSET: begin
            off_nxt = off_e | byte_sh;
            if (idx_inc < os_r) begin
              idx_nxt = idx_inc;
            end else begin
              idx_nxt       = '0;
              phase_nxt     = PH_HEADER;
              cmd_push      = 1'b1;
              cmd_word.kind = CMD_RUN;
            end
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
      // a list start travels with the next command the back sees
      clr_pend_nxt = cmd_push ? 1'b0 : (clr_pend_r | in_word.list_start);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      ls_r       <= '0;
      os_r       <= '0;
      idx_r      <= '0;
      len_r      <= '0;
      off_r      <= '0;
      fin_r      <= 1'b0;
      clr_pend_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      ls_r       <= ls_nxt;
      os_r       <= os_nxt;
      idx_r      <= idx_nxt;
      len_r      <= len_nxt;
      off_r      <= off_nxt;
      fin_r      <= fin_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/crld_cmd_queue.sv -----
// short command queue between the parser and the run arithmetic
`default_nettype none

module crld_cmd_queue import crld_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_word,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_word,
  output logic      empty
);

  cmd_t                  mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_r, rd_r;
  logic [CMDQ_PTR_W:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_word = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

// ----- src/crld_back.sv -----
// run arithmetic: start cluster, byte address, byte total and result queue
`default_nettype none

module crld_back import crld_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cmd_valid,
  input  wire cmd_t                cmd_word,
  output logic                     cmd_pop,
  input  wire logic [CB_W-1:0]     cluster_bytes,
  input  wire logic [STREAM_W-1:0] stream_bytes,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output out_word_t                out_word
);

  typedef struct packed {
    logic             clr;
    cmd_kind_t        kind;
    logic [1:0]       status;
    logic             fail;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] len;
  } stage_t;

  function automatic logic [ACC_W-1:0] sign_ext(input logic [ACC_W-1:0] acc,
                                                input logic [3:0] size);
    logic [ACC_W-1:0] d;
    d = acc;
    for (int i = 1; i < ACC_W / 8; i++) begin
      if (size == 4'(i) && acc[8*i-1]) begin
        d = acc | ({ACC_W{1'b1}} << (8 * i));
      end
    end
    return d;
  endfunction

  logic                adv;
  logic [CNT_W-1:0]    prev_r, prev_nxt, base_a;
  logic [ACC_W-1:0]    delta_a;
  logic [SUM_W-1:0]    sum_a;
  stage_t              a_nxt;
  logic                a_v_r;
  stage_t              a_r;
  logic                b_v_r;
  stage_t              b_r;
  logic [PROD_W-1:0]   b_addr_prod_r, b_len_prod_r;

  logic [ACC_W-1:0]    bt_r, bt_nxt, bt_base, bt_new;
  logic [PROD_W:0]     bt_sum;
  logic                fin_r, fin_nxt, fin_base;
  logic                addr_ovf, run_done, emit;
  out_word_t           res;

  out_word_t           oq_mem_r [OQ_DEPTH];
  logic                oq_wr_r, oq_rd_r;
  logic [1:0]          oq_cnt_r, oq_cnt_nxt;
  logic                oq_full, oq_pop;

  assign oq_full   = (oq_cnt_r == 2'(OQ_DEPTH));
  assign out_empty = (oq_cnt_r == 2'd0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_word  = oq_mem_r[oq_rd_r];

  // the whole pipe moves unless the last stage cannot unload
  assign adv     = !(b_v_r && oq_full);
  assign cmd_pop = adv && cmd_valid;

  // stage a: signed delta against the previous start
  always_comb begin
    base_a  = cmd_word.clr ? '0 : prev_r;
    delta_a = sign_ext(cmd_word.off_acc, cmd_word.off_size);
    sum_a   = SUM_W'(base_a) + {delta_a[ACC_W-1], delta_a};

    a_nxt.clr    = cmd_word.clr;
    a_nxt.kind   = cmd_word.kind;
    a_nxt.status = cmd_word.status;
    // below zero or past the cluster limit, or count wider than 48 bits
    a_nxt.fail   = (sum_a[SUM_W-1:LIMIT_BITS] != '0) ||
                   (cmd_word.len_acc[ACC_W-1:CNT_W] != '0);
    a_nxt.start  = sum_a[CNT_W-1:0];
    a_nxt.len    = cmd_word.len_acc[CNT_W-1:0];

    prev_nxt = prev_r;
    if (cmd_pop) begin
      prev_nxt = (cmd_word.kind == CMD_RUN && !a_nxt.fail) ? a_nxt.start : base_a;
    end
  end

  // stage c: address check, byte total, end of list
  always_comb begin
    bt_base  = b_r.clr ? '0 : bt_r;
    fin_base = b_r.clr ? 1'b0 : fin_r;
    bt_sum   = (PROD_W + 1)'(bt_base) + (PROD_W + 1)'(b_len_prod_r);
    bt_new   = (bt_sum[PROD_W:ACC_W] != '0) ? {ACC_W{1'b1}} : bt_sum[ACC_W-1:0];
    addr_ovf = (b_addr_prod_r[PROD_W-1:ADDR_W] != '0);
    run_done = (stream_bytes != '0) && (bt_new >= ACC_W'(stream_bytes));

    res     = '0;
    emit    = 1'b0;
    bt_nxt  = bt_r;
    fin_nxt = fin_r;
    if (b_v_r && adv) begin
      bt_nxt  = bt_base;
      fin_nxt = fin_base;
      if (!fin_base) begin
        emit          = 1'b1;
        res.list_done = 1'b1;
        fin_nxt       = 1'b1;
        if (b_r.kind == CMD_END) begin
          res.status = b_r.status;
        end else if (b_r.fail || addr_ovf) begin
          res.status = ST_RANGE;
        end else begin
          res.run_valid     = 1'b1;
          res.run_start     = b_r.start;
          res.cluster_count = b_r.len;
          res.byte_address  = b_addr_prod_r[ADDR_W-1:0];
          res.list_done     = run_done;
          res.status        = ST_OK;
          bt_nxt            = bt_new;
          fin_nxt           = run_done;
        end
      end
    end
  end

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (emit && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 2'd1;
    end else if (oq_pop && !emit) begin
      oq_cnt_nxt = oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      a_v_r    <= 1'b0;
      b_v_r    <= 1'b0;
      bt_r     <= '0;
      fin_r    <= 1'b0;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      prev_r   <= prev_nxt;
      bt_r     <= bt_nxt;
      fin_r    <= fin_nxt;
      oq_cnt_r <= oq_cnt_nxt;
      if (adv) begin
        a_v_r <= cmd_valid;
        b_v_r <= a_v_r;
      end
      if (emit) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (oq_pop) begin
        oq_rd_r <= ~oq_rd_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r           <= a_nxt;
      b_r           <= a_r;
      b_addr_prod_r <= PROD_W'(a_r.start) * PROD_W'(cluster_bytes);
      b_len_prod_r  <= PROD_W'(a_r.len) * PROD_W'(cluster_bytes);
    end
    if (emit) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

endmodule

`default_nettype wire

// ----- src/cluster_run_list_decoder_top.sv -----
// top level of the cluster run list decoder with its configuration registers
`default_nettype none

// Decodes a file system run list fed one byte per word. Each run is a header
// byte (low nibble: length field size, high nibble: offset field size) and two
// little-endian fields; the offset is a signed delta from the previous run's
// start. One result word comes out per completed run with start cluster, count
// and byte address (start times sector_bytes times cluster_sectors), and one
// per end marker or bad header. A list ends at an offset size of zero, a nibble
// above 8, a value out of range, or once the byte total reaches stream_bytes
// (zero disables that check); later bytes are dropped until list_start.
// Rate: one input word per clock while the command queue has room, whatever
// the run layout; the parser never stalls, and the run arithmetic retires one
// command per cycle unless the result queue is full, limited by the 65-bit
// start cluster add that feeds the next run. Results pass the command queue,
// registers a and b, then the output queue. No clearing pass after reset.
// Registers (64-bit data, byte address 8*i): 0 sector_bytes, 1 cluster_sectors,
// 2 stream_bytes; write only while the block is idle.

module cluster_run_list_decoder_top import crld_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input queue side
  input  wire logic                  push,
  output logic                       full,
  input  wire in_word_t              in_word,
  // result queue side
  output logic                       empty,
  input  wire logic                  pop,
  output out_word_t                  out_word,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  // config registers
  logic [SECTOR_W-1:0] sector_bytes_r;
  logic [CSECT_W-1:0]  cluster_sectors_r;
  logic [STREAM_W-1:0] stream_bytes_r;
  logic [CB_W-1:0]     cluster_bytes_r, cluster_bytes_nxt;
  reg_idx_t            reg_idx;
  logic                cfg_wr;

  // front to queue to back
  logic in_accept;
  logic cmd_push;
  cmd_t cmd_in, cmd_out;
  logic cmdq_empty;
  logic cmd_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // cluster size in bytes, precomputed so the back sees one operand
  assign cluster_bytes_nxt = CB_W'(sector_bytes_r) * CB_W'(cluster_sectors_r);

  always_comb begin
    case (reg_idx)
      REG_SECTOR_BYTES:    prdata = CFG_DATA_W'(sector_bytes_r);
      REG_CLUSTER_SECTORS: prdata = CFG_DATA_W'(cluster_sectors_r);
      REG_STREAM_BYTES:    prdata = CFG_DATA_W'(stream_bytes_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_bytes_r    <= SECTOR_W'(512);
      cluster_sectors_r <= CSECT_W'(8);
      stream_bytes_r    <= '0;
      cluster_bytes_r   <= CB_W'(4096);
    end else begin
      cluster_bytes_r <= cluster_bytes_nxt;
      if (cfg_wr) begin
        case (reg_idx)
          REG_SECTOR_BYTES:    sector_bytes_r    <= pwdata[SECTOR_W-1:0];
          REG_CLUSTER_SECTORS: cluster_sectors_r <= pwdata[CSECT_W-1:0];
          REG_STREAM_BYTES:    stream_bytes_r    <= pwdata[STREAM_W-1:0];
          default:             ;
        endcase
      end
    end
  end

  // a byte is taken whenever the command queue has room
  assign in_accept = push && !full;

  crld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .in_word  (in_word),
    .cmd_push (cmd_push),
    .cmd_word (cmd_in)
  );

  crld_cmd_queue u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_word (cmd_in),
    .full      (full),
    .pop       (cmd_pop),
    .pop_word  (cmd_out),
    .empty     (cmdq_empty)
  );

  crld_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (!cmdq_empty),
    .cmd_word      (cmd_out),
    .cmd_pop       (cmd_pop),
    .cluster_bytes (cluster_bytes_r),
    .stream_bytes  (stream_bytes_r),
    .out_empty     (empty),
    .out_pop       (pop),
    .out_word      (out_word)
  );

endmodule

`default_nettype wire

// ----- dv/crld_run_checker.sv -----
// checker for the cluster run list decoder: watches both queues and the register port
`timescale 1ns / 100ps

module crld_run_checker import crld_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic                  full,
  input  wire in_word_t              in_word,
  input  wire logic                  empty,
  input  wire logic                  pop,
  input  wire out_word_t             out_word,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  input  wire logic                  pready,
  output int                         mismatches,
  output int                         outstanding
);

  localparam logic [63:0] CNT_MAX  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] ADDR_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    AWAIT_HEADER,
    AWAIT_LENGTH,
    AWAIT_OFFSET
  } parse_state_t;

  logic [SECTOR_W-1:0] sector_bytes_cfg;
  logic [CSECT_W-1:0]  cluster_sectors_cfg;
  logic [STREAM_W-1:0] stream_bytes_cfg;

  parse_state_t parse_state;
  int unsigned  len_size;
  int unsigned  off_size;
  int unsigned  byte_idx;
  logic [63:0]  len_acc;
  logic [63:0]  off_acc;
  logic [63:0]  prev_cluster;
  logic [63:0]  byte_total;
  bit           list_ended;

  out_word_t expected_runs[$];

  function automatic out_word_t make_word(logic valid, logic [47:0] start,
                                          logic [47:0] count, logic [62:0] addr,
                                          logic done, logic [1:0] status);
    out_word_t w;
    w.run_valid     = valid;
    w.run_start     = start;
    w.cluster_count = count;
    w.byte_address  = addr;
    w.list_done     = done;
    w.status        = status;
    return w;
  endfunction

  function automatic out_word_t range_fail();
    list_ended = 1'b1;
    return make_word(1'b0, '0, '0, '0, 1'b1, ST_RANGE);
  endfunction

  // start cluster from the signed delta, then count, address and byte total
  function automatic out_word_t close_run();
    logic [63:0] lim;
    logic [63:0] clus_bytes;
    logic [63:0] delta;
    logic [63:0] low_mask;
    logic [63:0] mag;
    logic [63:0] start;
    logic [63:0] addr;
    logic        done;
    int unsigned nbits;
    lim        = (64'd1 << LIMIT_BITS) - 64'd1;
    clus_bytes = 64'(sector_bytes_cfg) * 64'(cluster_sectors_cfg);
    delta      = off_acc;
    if (off_size < 8) begin
      nbits    = off_size * 8;
      low_mask = (64'd1 << nbits) - 64'd1;
      delta    = delta & low_mask;
      if (delta[nbits-1]) delta = delta | ~low_mask;
    end
    if (delta[63]) begin
      mag = ~delta + 64'd1;
      if (mag > prev_cluster) return range_fail();
      start = prev_cluster - mag;
    end else begin
      if (prev_cluster > lim || delta > lim - prev_cluster) return range_fail();
      start = prev_cluster + delta;
    end
    if (len_acc > CNT_MAX) return range_fail();
    if (clus_bytes != 0 && start > ADDR_MAX / clus_bytes) return range_fail();
    addr         = start * clus_bytes;
    prev_cluster = start;
    if (clus_bytes != 0) begin
      if (len_acc > (ALL_ONES - byte_total) / clus_bytes) byte_total = ALL_ONES;
      else byte_total = byte_total + len_acc * clus_bytes;
    end
    done = (stream_bytes_cfg != 0) && (byte_total >= 64'(stream_bytes_cfg));
    if (done) list_ended = 1'b1;
    return make_word(1'b1, start[47:0], len_acc[47:0], addr[62:0], done, ST_OK);
  endfunction

  function automatic void take_byte(in_word_t w);
    logic [7:0] b;
    logic [3:0] ls;
    logic [3:0] os;
    b = w.run_byte;
    if (w.list_start) begin
      prev_cluster = '0;
      byte_total   = '0;
      list_ended   = 1'b0;
      parse_state  = AWAIT_HEADER;
      byte_idx     = 0;
      len_acc      = '0;
      off_acc      = '0;
    end
    if (list_ended) return;
    case (parse_state)
      AWAIT_HEADER: begin
        ls = b[3:0];
        os = b[7:4];
        if (os == 0) begin
          list_ended = 1'b1;
          expected_runs.push_back(make_word(1'b0, '0, '0, '0, 1'b1, ST_OK));
        end else if (ls > MAX_FIELD_BYTES || os > MAX_FIELD_BYTES) begin
          list_ended = 1'b1;
          expected_runs.push_back(make_word(1'b0, '0, '0, '0, 1'b1, ST_BAD_NIBBLE));
        end else begin
          len_size    = ls;
          off_size    = os;
          len_acc     = '0;
          off_acc     = '0;
          byte_idx    = 0;
          parse_state = (ls != 0) ? AWAIT_LENGTH : AWAIT_OFFSET;
        end
      end
      AWAIT_LENGTH: begin
        len_acc  = len_acc | (64'(b) << (8 * (byte_idx % 8)));
        byte_idx = byte_idx + 1;
        if (byte_idx >= len_size) begin
          byte_idx    = 0;
          parse_state = AWAIT_OFFSET;
        end
      end
      default: begin
        off_acc  = off_acc | (64'(b) << (8 * (byte_idx % 8)));
        byte_idx = byte_idx + 1;
        if (byte_idx >= off_size) begin
          byte_idx    = 0;
          parse_state = AWAIT_HEADER;
          expected_runs.push_back(close_run());
        end
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (expected_runs.size() == 0) begin
      mismatches++;
      $display("%0t: result word expected none got %h", $time, got);
    end else begin
      want = expected_runs.pop_front();
      check_field("run_valid", 64'(want.run_valid), 64'(got.run_valid));
      check_field("run_start", 64'(want.run_start), 64'(got.run_start));
      check_field("cluster_count", 64'(want.cluster_count), 64'(got.cluster_count));
      check_field("byte_address", 64'(want.byte_address), 64'(got.byte_address));
      check_field("list_done", 64'(want.list_done), 64'(got.list_done));
      check_field("status", 64'(want.status), 64'(got.status));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sector_bytes_cfg    = 13'd512;
      cluster_sectors_cfg = 8'd8;
      stream_bytes_cfg    = '0;
      parse_state         = AWAIT_HEADER;
      len_size            = 0;
      off_size            = 0;
      byte_idx            = 0;
      len_acc             = '0;
      off_acc             = '0;
      prev_cluster        = '0;
      byte_total          = '0;
      list_ended          = 1'b0;
      mismatches          = 0;
      expected_runs.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr >> 3))
          REG_SECTOR_BYTES:    sector_bytes_cfg    = pwdata[SECTOR_W-1:0];
          REG_CLUSTER_SECTORS: cluster_sectors_cfg = pwdata[CSECT_W-1:0];
          REG_STREAM_BYTES:    stream_bytes_cfg    = pwdata[STREAM_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) take_byte(in_word);
      if (pop && !empty) check_result(out_word);
    end
    outstanding = expected_runs.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// top of the cluster run list decoder testbench: stimulus, register writes and verdict
`timescale 1ns / 100ps

module tb_top;
  import crld_pkg::*;

  localparam int RANDOM_WORDS    = 550;
  localparam int PHASE_WORDS     = 70;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT      = 3000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 16;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  in_word_t              in_word;
  logic                  empty;
  logic                  pop;
  out_word_t             out_word;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int check_errors;
  int pending_runs;
  int idle_cycles;
  int words_sent;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_off_req;

  always #5 clk = ~clk;

  cluster_run_list_decoder_top dut (
    .clk, .rst_n,
    .push, .full, .in_word,
    .empty, .pop, .out_word,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  crld_run_checker checker_i (
    .clk, .rst_n,
    .push, .full, .in_word,
    .empty, .pop, .out_word,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches  (check_errors),
    .outstanding (pending_runs)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // field sizes lean small, the wide ones show up less often
  function automatic int pick_size(bit allow_zero);
    int roll;
    roll = $urandom_range(99);
    if (allow_zero && roll < 10) return 0;
    if (roll < 60) return $urandom_range(1, 2);
    if (roll < 85) return $urandom_range(3, 4);
    return $urandom_range(5, 8);
  endfunction

  // hand one word to the input queue; entered and left at a falling edge
  task automatic push_word(input logic [7:0] b, input logic list_head, input bit counted);
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
    push    <= 1'b1;
    in_word <= '{run_byte: b, list_start: list_head};
    do @(posedge clk); while (full);
    if (counted) words_sent++;
    @(negedge clk);
  endtask

  // setup phase, access phase, then a quiet gap so back-to-back writes don't collide
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // little-endian field; wide fields mostly get a zero top byte so runs stay in range
  task automatic send_field(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if (i == n - 1 && n >= 4 && $urandom_range(99) < 70) b = 8'h00;
      push_word(b, 1'b0, 1'b1);
    end
  endtask

  // wait for every result, then a few cycles for words that give none
  task automatic settle();
    push <= 1'b0;
    while (pending_runs != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one run list: mostly well formed runs with random content, some noise
  task automatic send_list();
    int  runs;
    int  ls;
    int  os;
    int  roll;
    logic list_head;
    list_head = 1'b1;
    roll = $urandom_range(99);
    // noise: random bytes with stray list starts
    if (roll < 10) begin
      repeat ($urandom_range(1, 12)) begin
        push_word(8'($urandom_range(255)), list_head | ($urandom_range(3) == 0), 1'b1);
        list_head = 1'b0;
      end
      return;
    end
    runs = $urandom_range(1, 6);
    for (int r = 0; r < runs; r++) begin
      roll = $urandom_range(99);
      // bad header nibble on either side, list is over afterwards
      if (roll < 5) begin
        if ($urandom_range(1)) begin
          os = $urandom_range(9, 15);
          ls = $urandom_range(0, 15);
        end else begin
          os = $urandom_range(1, 15);
          ls = $urandom_range(9, 15);
        end
        push_word({4'(os), 4'(ls)}, list_head, 1'b1);
        return;
      end
      ls = pick_size(1'b1);
      os = pick_size(1'b0);
      push_word({4'(os), 4'(ls)}, list_head, 1'b1);
      list_head = 1'b0;
      send_field(ls);
      // cut off mid-run now and then, next list start must clear it
      if (roll > 96) return;
      send_field(os);
    end
    roll = $urandom_range(99);
    if (roll < 80) push_word({4'h0, 4'($urandom_range(15))}, 1'b0, 1'b1);
    // trailing words after the end marker are dropped by the block
    if (roll >= 60 && roll < 80) begin
      repeat ($urandom_range(1, 2)) push_word(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  // result side: random pops, and one long hold-off on request
  initial begin
    int gap_left;
    gap_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (gap_left > 0) begin
        pop <= 1'b0;
        gap_left--;
      end else if ($urandom_range(99) < rx_idle_pct) begin
        pop <= 1'b0;
        gap_left = gap_len() - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog: any accepted or popped word or register write resets the count
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [8:0]            directed_words[$];
    logic [CFG_DATA_W-1:0] sect_val;
    logic [CFG_DATA_W-1:0] csect_val;
    logic [CFG_DATA_W-1:0] stream_val;
    int                    phase_no;
    int                    phase_base;
    rst_n        = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    in_word      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    words_sent   = 0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_off_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset config, top bit is list_start:
    // plain run, negative delta below zero, dropped word after the end,
    // end marker, bad nibbles (both, offset only, length only),
    // empty length field, wide positive offset, short negative offset,
    // end marker with a nonzero low nibble
    directed_words = '{9'h111, 9'h010, 9'h020,
                       9'h011, 9'h0FF, 9'h080,
                       9'h022,
                       9'h100,
                       9'h1FF,
                       9'h190,
                       9'h119,
                       9'h110, 9'h07F,
                       9'h061, 9'h001, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,
                       9'h010, 9'h080,
                       9'h00A};
    foreach (directed_words[i]) push_word(directed_words[i][7:0], directed_words[i][8], 1'b1);

    // random part in phases, each with its own register setting
    words_sent = 0;
    phase_no   = 1;
    while (words_sent < RANDOM_WORDS) begin
      settle();
      case (phase_no)
        1: begin sect_val = 4096; csect_val = 128; stream_val = 0; end
        2: begin sect_val = 256;  csect_val = 1;   stream_val = 0; end
        3: begin sect_val = 512;  csect_val = 8;   stream_val = $urandom_range(1, 1 << 22); end
        4: begin sect_val = 0;    csect_val = 8;   stream_val = 1000; end
        5: begin sect_val = 8191; csect_val = 255; stream_val = 64'h0000_FFFF_FFFF_FFFF; end
        6: begin sect_val = 256;  csect_val = 0;   stream_val = 1; end
        default: begin
          sect_val   = $urandom_range(256, 4096);
          csect_val  = $urandom_range(1, 128);
          stream_val = $urandom_range(1) ? 64'd0 : 64'($urandom_range(1, 1 << 26));
        end
      endcase
      write_reg(REG_SECTOR_BYTES, sect_val);
      write_reg(REG_CLUSTER_SECTORS, csect_val);
      write_reg(REG_STREAM_BYTES, stream_val);

      // rotate through no idling, sender-only idling and idling on both sides
      case (phase_no % 3)
        0: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        1: begin tx_idle_pct = $urandom_range(5, 40); rx_idle_pct = 0; end
        default: begin tx_idle_pct = $urandom_range(5, 40); rx_idle_pct = $urandom_range(5, 40); end
      endcase
      // back-pressure phase: result side holds off while words keep coming
      if (phase_no == 1) begin
        tx_idle_pct  = 0;
        hold_off_req = 1'b1;
      end

      phase_base = words_sent;
      while (words_sent - phase_base < PHASE_WORDS && words_sent < RANDOM_WORDS) send_list();
      phase_no++;
    end

    // drain, let the pipeline empty out, then the verdict
    push <= 1'b0;
    while (pending_runs != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (check_errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
